[rtl/core/prat_pkg.sv]
// shared constants, codes and control types for the reorder and ack tracker
`timescale 1ns / 1ps
`default_nettype none
package prat_pkg;

  localparam int SEQ_W         = 16;
  localparam int HANDLE_W      = 8;
  localparam int RES_KIND_W    = 3;
  localparam int PKT_KIND_W    = 2;
  localparam int REORDER_DEPTH = 16;
  localparam int RIDX_W        = $clog2(REORDER_DEPTH);
  localparam int RESEND_DEPTH  = 64;
  localparam int SLOT_W        = $clog2(RESEND_DEPTH);
  localparam int MAX_GAP_NACKS = 32;
  localparam int NACK_W        = $clog2(MAX_GAP_NACKS + 1);
  localparam int RESULT_CAP    = 33;
  localparam int CNT_W         = $clog2(RESULT_CAP + 1);

  // packet kinds
  localparam logic [PKT_KIND_W-1:0] PKT_DATA      = 2'd0;
  localparam logic [PKT_KIND_W-1:0] PKT_ACK       = 2'd1;
  localparam logic [PKT_KIND_W-1:0] PKT_HEARTBEAT = 2'd2;

  // result kinds
  localparam logic [RES_KIND_W-1:0] RES_DELIVER   = 3'd0;
  localparam logic [RES_KIND_W-1:0] RES_POS_ACK   = 3'd1;
  localparam logic [RES_KIND_W-1:0] RES_RETRY     = 3'd2;
  localparam logic [RES_KIND_W-1:0] RES_RESEND    = 3'd3;
  localparam logic [RES_KIND_W-1:0] RES_SEND_TRK  = 3'd4;
  localparam logic [RES_KIND_W-1:0] RES_SEND_UNTR = 3'd5;

  // controller states, also the step code given to the datapath
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH = 4'd1;
  localparam logic [OP_W-1:0] OP_ACKCHK   = 4'd2;
  localparam logic [OP_W-1:0] OP_DATA     = 4'd3;
  localparam logic [OP_W-1:0] OP_NACK     = 4'd4;
  localparam logic [OP_W-1:0] OP_STORE    = 4'd5;
  localparam logic [OP_W-1:0] OP_SCAN     = 4'd6;
  localparam logic [OP_W-1:0] OP_JUMP     = 4'd7;
  localparam logic [OP_W-1:0] OP_DRAIN    = 4'd8;
  localparam logic [OP_W-1:0] OP_FLUSH    = 4'd9;

  typedef struct packed {
    logic            go;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic                  emit_ok;
    logic                  func;
    logic                  en;
    logic                  good;
    logic [PKT_KIND_W-1:0] kind;
    logic                  late;
    logic                  at_exp;
    logic                  full;
    logic                  nack_end;
    logic                  scan_end;
    logic                  drain_stop;
  } status_t;

endpackage
`default_nettype wire

[rtl/core/packet_reorder_ack_tracker.sv]
// top level of the packet reorder and acknowledgement tracker
`timescale 1ns / 1ps
`default_nettype none
// Selective-repeat sequence tracker. One word is taken when the block is idle
// and worked through by a small sequencer; results leave through a one-deep
// output register, one per cycle while the receiver does not stall. Each word
// passes a dispatch and a flush state; an acknowledgement adds a check state
// after the registered resend memory read. A data packet that meets a full
// reorder table adds a scan of the table to find the nearest buffered number.
// The en_q register resets to 1; it is to be written through cfg_we_i only
// while the block is idle, and the block itself does not enforce this.
module packet_reorder_ack_tracker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire                                cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                func_i,
  input  wire [prat_pkg::PKT_KIND_W-1:0]     pkt_kind_i,
  input  wire                                pkt_good_i,
  input  wire [prat_pkg::SEQ_W-1:0]          pkt_seq_i,
  input  wire [prat_pkg::HANDLE_W-1:0]       pkt_handle_i,
  input  wire                                ack_retry_i,
  input  wire [prat_pkg::SEQ_W-1:0]          ack_seq_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [prat_pkg::RES_KIND_W-1:0]    res_kind_o,
  output logic [prat_pkg::SEQ_W-1:0]         res_seq_o,
  output logic [prat_pkg::HANDLE_W-1:0]      res_handle_o,
  output logic                               res_last_o
);

  prat_pkg::cmd_t    cmd;
  prat_pkg::status_t st;

  prat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  prat_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .pkt_kind_i   (pkt_kind_i),
    .pkt_good_i   (pkt_good_i),
    .pkt_seq_i    (pkt_seq_i),
    .pkt_handle_i (pkt_handle_i),
    .ack_retry_i  (ack_retry_i),
    .ack_seq_i    (ack_seq_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_kind_o   (res_kind_o),
    .res_seq_o    (res_seq_o),
    .res_handle_o (res_handle_o),
    .res_last_o   (res_last_o)
  );

endmodule
`default_nettype wire

[rtl/core/prat_ctrl.sv]
// controller state machine stepping through one input word
`timescale 1ns / 1ps
`default_nettype none
module prat_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire prat_pkg::status_t st_i,
  output prat_pkg::cmd_t         cmd_o
);

  logic [prat_pkg::OP_W-1:0] state_q, state_d;
  logic                      go;

  assign go         = (state_q == prat_pkg::OP_IDLE) ? in_valid_i : st_i.emit_ok;
  assign in_stall_o = (state_q != prat_pkg::OP_IDLE);
  assign cmd_o.go   = go;
  assign cmd_o.op   = state_q;

  always_comb begin
    state_d = state_q;
    if (go) begin
      unique case (state_q)
        prat_pkg::OP_IDLE: state_d = prat_pkg::OP_DISPATCH;
        prat_pkg::OP_DISPATCH: begin
          if (st_i.func || !st_i.en || !st_i.good || st_i.kind == prat_pkg::PKT_HEARTBEAT)
            state_d = prat_pkg::OP_FLUSH;
          else if (st_i.kind == prat_pkg::PKT_ACK)
            state_d = prat_pkg::OP_ACKCHK;
          else
            state_d = prat_pkg::OP_DATA;
        end
        prat_pkg::OP_ACKCHK: state_d = prat_pkg::OP_FLUSH;
        prat_pkg::OP_DATA: begin
          if (st_i.late)        state_d = prat_pkg::OP_FLUSH;
          else if (st_i.at_exp) state_d = prat_pkg::OP_DRAIN;
          else if (st_i.full)   state_d = prat_pkg::OP_SCAN;
          else                  state_d = prat_pkg::OP_NACK;
        end
        prat_pkg::OP_NACK:  if (st_i.nack_end) state_d = prat_pkg::OP_STORE;
        prat_pkg::OP_STORE: state_d = prat_pkg::OP_FLUSH;
        prat_pkg::OP_SCAN:  if (st_i.scan_end) state_d = prat_pkg::OP_JUMP;
        prat_pkg::OP_JUMP:  state_d = prat_pkg::OP_DRAIN;
        prat_pkg::OP_DRAIN: if (st_i.drain_stop) state_d = prat_pkg::OP_FLUSH;
        prat_pkg::OP_FLUSH: state_d = prat_pkg::OP_IDLE;
        default:            state_d = prat_pkg::OP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prat_pkg::OP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/prat_dp.sv]
// datapath: sequence state, reorder table, resend memory and result staging
`timescale 1ns / 1ps
`default_nettype none
module prat_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire prat_pkg::cmd_t                    cmd_i,
  output prat_pkg::status_t                      st_o,
  input  wire                                   cfg_we_i,
  input  wire                                   cfg_data_i,
  input  wire                                   func_i,
  input  wire [prat_pkg::PKT_KIND_W-1:0]        pkt_kind_i,
  input  wire                                   pkt_good_i,
  input  wire [prat_pkg::SEQ_W-1:0]             pkt_seq_i,
  input  wire [prat_pkg::HANDLE_W-1:0]          pkt_handle_i,
  input  wire                                   ack_retry_i,
  input  wire [prat_pkg::SEQ_W-1:0]             ack_seq_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [prat_pkg::RES_KIND_W-1:0]       res_kind_o,
  output logic [prat_pkg::SEQ_W-1:0]            res_seq_o,
  output logic [prat_pkg::HANDLE_W-1:0]         res_handle_o,
  output logic                                  res_last_o
);

  localparam int SW = prat_pkg::SEQ_W;
  localparam int HW = prat_pkg::HANDLE_W;
  localparam int RD = prat_pkg::REORDER_DEPTH;
  localparam int IW = prat_pkg::RIDX_W;

  // latched input word
  logic                           func_q, good_q, retry_q;
  logic [prat_pkg::PKT_KIND_W-1:0] kind_q;
  logic [SW-1:0]                  seq_q, aseq_q;
  logic [HW-1:0]                  h_q;

  logic          en_q;
  logic [SW-1:0] exp_q, outs_q;

  logic [RD-1:0] rv_q;
  logic [SW-1:0] rseq_q [RD];
  logic [HW-1:0] rh_q   [RD];

  logic [prat_pkg::RESEND_DEPTH-1:0] rsv_q;
  logic [SW-1:0] rs_seq_m [prat_pkg::RESEND_DEPTH];
  logic [HW-1:0] rs_h_m   [prat_pkg::RESEND_DEPTH];
  logic [SW-1:0] rd_seq_q;
  logic [HW-1:0] rd_h_q;

  logic [prat_pkg::NACK_W-1:0] k_q, gapn_q;
  logic [prat_pkg::CNT_W-1:0]  cnt_q;
  logic [IW-1:0]               sidx_q, besti_q;
  logic                        bestv_q;
  logic [SW-1:0]               bestd_q, bests_q;
  logic [HW-1:0]               besth_q;

  logic                            pend_v_q, out_v_q, out_last_q;
  logic [prat_pkg::RES_KIND_W-1:0] pend_k_q, out_k_q;
  logic [SW-1:0]                   pend_s_q, out_s_q;
  logic [HW-1:0]                   pend_h_q, out_h_q;

  // derived values
  logic          go;
  logic [SW-1:0] behind, gap, nxt, key, scan_d;
  logic          late, at_exp, full, is_send_trk, ack_hit;
  logic [RD-1:0] match;
  logic          hit, has_free;
  logic [IW-1:0] hit_idx, free_idx, st_idx;
  logic [prat_pkg::SLOT_W-1:0] out_slot, ack_slot;
  logic          slot_free, emit_ok, cap_ok;
  logic          em, emit_fire, flush_fire;
  logic [prat_pkg::RES_KIND_W-1:0] em_k;
  logic [SW-1:0] em_s;
  logic [HW-1:0] em_h;

  assign go       = cmd_i.go;
  assign behind   = exp_q - seq_q;
  assign gap      = seq_q - exp_q;
  assign late     = (behind != '0) && !behind[SW-1];
  assign at_exp   = (seq_q == exp_q);
  assign full     = &rv_q;
  assign nxt      = exp_q + SW'(1);
  assign key      = (cmd_i.op == prat_pkg::OP_DRAIN) ? nxt : seq_q;
  assign scan_d   = rseq_q[sidx_q] - exp_q - SW'(1);
  assign out_slot = outs_q[prat_pkg::SLOT_W-1:0];
  assign ack_slot = aseq_q[prat_pkg::SLOT_W-1:0];
  assign ack_hit  = rsv_q[ack_slot] && (rd_seq_q == aseq_q);
  assign is_send_trk = en_q && !(kind_q == prat_pkg::PKT_ACK ||
                                 kind_q == prat_pkg::PKT_HEARTBEAT);
  assign cap_ok   = (cnt_q < prat_pkg::CNT_W'(prat_pkg::RESULT_CAP));

  // lookup of the key and the first free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    has_free = 1'b0;
    for (int i = RD - 1; i >= 0; i--) begin
      match[i] = rv_q[i] && (rseq_q[i] == key);
      if (match[i]) hit_idx = IW'(i);
      if (!rv_q[i]) begin
        free_idx = IW'(i);
        has_free = 1'b1;
      end
    end
  end
  assign hit    = |match;
  assign st_idx = hit ? hit_idx : free_idx;

  // staged result: one held back so the final one can be marked last
  assign slot_free = !out_v_q || !out_stall_i;
  assign emit_ok   = !pend_v_q || slot_free;

  always_comb begin
    em   = 1'b0;
    em_k = prat_pkg::RES_DELIVER;
    em_s = '0;
    em_h = '0;
    case (cmd_i.op)
      prat_pkg::OP_DISPATCH: begin
        em = 1'b1;
        if (func_q) begin
          if (kind_q == prat_pkg::PKT_ACK || kind_q == prat_pkg::PKT_HEARTBEAT) begin
            em_k = prat_pkg::RES_SEND_UNTR;
            em_h = h_q;
          end else if (!en_q) begin
            em_k = prat_pkg::RES_SEND_UNTR;
            em_s = outs_q;
            em_h = h_q;
          end else begin
            em_k = prat_pkg::RES_SEND_TRK;
            em_s = outs_q;
            em_h = h_q;
          end
        end else if (!en_q) begin
          em_k = prat_pkg::RES_DELIVER;
          em_s = seq_q;
          em_h = h_q;
        end else if (!good_q) begin
          em_k = prat_pkg::RES_RETRY;
          em_s = seq_q;
        end else if (kind_q == prat_pkg::PKT_ACK) begin
          em = 1'b0;
        end else if (kind_q == prat_pkg::PKT_HEARTBEAT) begin
          em_k = prat_pkg::RES_DELIVER;
          em_s = seq_q;
          em_h = h_q;
        end else begin
          em_k = prat_pkg::RES_POS_ACK;
          em_s = seq_q;
        end
      end
      prat_pkg::OP_ACKCHK: begin
        em   = ack_hit && retry_q;
        em_k = prat_pkg::RES_RESEND;
        em_s = aseq_q;
        em_h = rd_h_q;
      end
      prat_pkg::OP_DATA: begin
        em   = !late && at_exp;
        em_s = seq_q;
        em_h = h_q;
      end
      prat_pkg::OP_NACK: begin
        em   = 1'b1;
        em_k = prat_pkg::RES_RETRY;
        em_s = exp_q + SW'(k_q);
      end
      prat_pkg::OP_JUMP: begin
        em   = 1'b1;
        em_s = bests_q;
        em_h = besth_q;
      end
      prat_pkg::OP_DRAIN: begin
        em   = hit;
        em_s = nxt;
        em_h = rh_q[hit_idx];
      end
      default: em = 1'b0;
    endcase
  end

  assign emit_fire  = go && em && cap_ok;
  assign flush_fire = go && (cmd_i.op == prat_pkg::OP_FLUSH) && pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (emit_fire) begin
        pend_v_q <= 1'b1;
      end else if (flush_fire) begin
        pend_v_q <= 1'b0;
      end
      if ((emit_fire && pend_v_q) || flush_fire) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      pend_k_q <= em_k;
      pend_s_q <= em_s;
      pend_h_q <= em_h;
    end
    if ((emit_fire && pend_v_q) || flush_fire) begin
      out_k_q    <= pend_k_q;
      out_s_q    <= pend_s_q;
      out_h_q    <= pend_h_q;
      out_last_q <= flush_fire;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      exp_q   <= '0;
      outs_q  <= '0;
      rv_q    <= '0;
      rsv_q   <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      gapn_q  <= '0;
      sidx_q  <= '0;
      bestv_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_data_i;
      end
      if (emit_fire) begin
        cnt_q <= cnt_q + prat_pkg::CNT_W'(1);
      end
      if (go) begin
        case (cmd_i.op)
          prat_pkg::OP_IDLE: cnt_q <= '0;
          prat_pkg::OP_DISPATCH: begin
            if (func_q && is_send_trk) begin
              rsv_q[out_slot] <= 1'b1;
              outs_q          <= outs_q + SW'(1);
            end
          end
          prat_pkg::OP_ACKCHK: begin
            if (ack_hit && !retry_q) rsv_q[ack_slot] <= 1'b0;
          end
          prat_pkg::OP_DATA: begin
            if (!late) begin
              if (at_exp) begin
                if (hit) rv_q[hit_idx] <= 1'b0;
              end else if (full) begin
                sidx_q  <= '0;
                bestv_q <= 1'b0;
              end else begin
                k_q <= '0;
                if (gap > SW'(prat_pkg::MAX_GAP_NACKS))
                  gapn_q <= prat_pkg::NACK_W'(prat_pkg::MAX_GAP_NACKS);
                else
                  gapn_q <= gap[prat_pkg::NACK_W-1:0];
              end
            end
          end
          prat_pkg::OP_NACK: k_q <= k_q + prat_pkg::NACK_W'(1);
          prat_pkg::OP_STORE: begin
            if (hit || has_free) rv_q[st_idx] <= 1'b1;
          end
          prat_pkg::OP_SCAN: begin
            sidx_q <= sidx_q + IW'(1);
            if (rv_q[sidx_q] && (!bestv_q || scan_d < bestd_q)) bestv_q <= 1'b1;
          end
          prat_pkg::OP_JUMP: begin
            rv_q[besti_q] <= 1'b0;
            exp_q         <= bests_q;
          end
          prat_pkg::OP_DRAIN: begin
            exp_q <= nxt;
            if (hit && cap_ok) rv_q[hit_idx] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers and table contents
  always_ff @(posedge clk_i) begin
    if (go && cmd_i.op == prat_pkg::OP_IDLE) begin
      func_q  <= func_i;
      kind_q  <= pkt_kind_i;
      good_q  <= pkt_good_i;
      seq_q   <= pkt_seq_i;
      h_q     <= pkt_handle_i;
      retry_q <= ack_retry_i;
      aseq_q  <= ack_seq_i;
    end
    if (go && cmd_i.op == prat_pkg::OP_STORE && (hit || has_free)) begin
      rseq_q[st_idx] <= seq_q;
      rh_q[st_idx]   <= h_q;
    end
    if (go && cmd_i.op == prat_pkg::OP_SCAN &&
        rv_q[sidx_q] && (!bestv_q || scan_d < bestd_q)) begin
      bestd_q <= scan_d;
      besti_q <= sidx_q;
      bests_q <= rseq_q[sidx_q];
      besth_q <= rh_q[sidx_q];
    end
  end

  // resend memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (go && cmd_i.op == prat_pkg::OP_DISPATCH && func_q && is_send_trk) begin
      rs_seq_m[out_slot] <= outs_q;
      rs_h_m[out_slot]   <= h_q;
    end
    rd_seq_q <= rs_seq_m[ack_slot];
    rd_h_q   <= rs_h_m[ack_slot];
  end

  assign st_o.emit_ok    = emit_ok;
  assign st_o.func       = func_q;
  assign st_o.en         = en_q;
  assign st_o.good       = good_q;
  assign st_o.kind       = kind_q;
  assign st_o.late       = late;
  assign st_o.at_exp     = at_exp;
  assign st_o.full       = full;
  assign st_o.nack_end   = (k_q == gapn_q - prat_pkg::NACK_W'(1));
  assign st_o.scan_end   = (sidx_q == IW'(RD - 1));
  assign st_o.drain_stop = !hit || !cap_ok;

  assign out_valid_o  = out_v_q;
  assign res_kind_o   = out_k_q;
  assign res_seq_o    = out_s_q;
  assign res_handle_o = out_h_q;
  assign res_last_o   = out_last_q;

endmodule
`default_nettype wire
